// File: src/lbd_pkg.sv
// shared constants, types and register codes for the linear blend deinterlacer
// no dependencies; every other file of the block but lbd_ram imports this package
`default_nettype none

package lbd_pkg;

    localparam int BYTE_W         = 8;
    localparam int MAX_ROW_BYTES  = 4096;
    localparam int COL_W          = $clog2(MAX_ROW_BYTES);
    localparam int MAX_FRAME_ROWS = 4096;
    localparam int MIN_FRAME_ROWS = 2;
    localparam int ROW_W          = $clog2(MAX_FRAME_ROWS);

    localparam int WIDTH_PIX_W    = 12;
    localparam int FRAME_ROWS_W   = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_IDX_W      = 1;

    localparam int WIDTH_PIX_RESET  = 720;
    localparam int FRAME_ROWS_RESET = 480;

    // row byte count is twice the pixel count, clamped to the line buffer size
    localparam int RB_W = (WIDTH_PIX_W + 1 > COL_W + 1) ? WIDTH_PIX_W + 1 : COL_W + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH_PIXELS = 1'b0,
        REG_FRAME_ROWS   = 1'b1
    } t_cfg_reg;

    // one queue entry per input byte that yields output
    typedef struct packed {
        logic [BYTE_W-1:0] blend;
        logic [BYTE_W-1:0] cur;
        logic              bottom_row;
        logic              row_end;
    } t_queue_entry;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              frame_end;
        logic              run_last;
    } t_result;

endpackage

`default_nettype wire

// File: src/lbd_pix_if.sv
// input byte channel: valid/ready handshake with one packed video byte
// depends on lbd_pkg
`default_nettype none

interface lbd_pix_if
    import lbd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] pixel_byte;

    modport source (output valid, output pixel_byte, input ready);
    modport sink   (input valid, input pixel_byte, output ready);
endinterface

`default_nettype wire

// File: src/lbd_res_if.sv
// result channel: valid/ready handshake with output byte and frame markers
// depends on lbd_pkg
`default_nettype none

interface lbd_res_if
    import lbd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              frame_end;
    logic              run_last;

    modport source (output valid, output out_byte, output frame_end, output run_last,
                    input ready);
    modport sink   (input valid, input out_byte, input frame_end, input run_last,
                    output ready);
endinterface

`default_nettype wire

// File: src/lbd_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module lbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: src/lbd_front.sv
// front end: config registers, row/column counters, line buffers and blend
// depends on lbd_pkg, lbd_pix_if, lbd_ram
`default_nettype none

module lbd_front
    import lbd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    lbd_pix_if.sink                    i_pix,
    input  wire logic [QUEUE_CW-1:0]   i_queue_count,
    output logic                       o_push,
    output t_queue_entry               o_entry
);

    logic [WIDTH_PIX_W-1:0]  r_width_pixels;
    logic [FRAME_ROWS_W-1:0] r_frame_rows;
    logic [COL_W-1:0]        r_col;
    logic [ROW_W-1:0]        r_row;

    logic                    r_s1_valid;
    logic                    r_s1_has_out;
    logic                    r_s1_first;
    logic                    r_s1_last;
    logic                    r_s1_end;
    logic [BYTE_W-1:0]       r_s1_cur;
    logic [COL_W-1:0]        r_s1_col;

    logic [WIDTH_PIX_W-1:0]  width_eff;
    logic [RB_W-1:0]         line_len;
    logic [COL_W-1:0]        line_len_m1;
    logic [FRAME_ROWS_W-1:0] rows_eff;
    logic [ROW_W-1:0]        rows_m1;
    logic                    row_end;
    logic                    on_bottom;
    logic                    accept;
    logic [BYTE_W-1:0]       above;
    logic [BYTE_W-1:0]       two_above;
    logic [BYTE_W:0]         sum_outer;
    logic [BYTE_W:0]         sum_inner;

    // effective geometry from the size registers
    always_comb begin
        width_eff = (r_width_pixels == '0) ? WIDTH_PIX_W'(1) : r_width_pixels;
        line_len = {(RB_W - WIDTH_PIX_W)'(0), width_eff} << 1;
        if (line_len > RB_W'(MAX_ROW_BYTES)) begin
            line_len = RB_W'(MAX_ROW_BYTES);
        end
        line_len_m1 = COL_W'(line_len - RB_W'(1));

        rows_eff = r_frame_rows;
        if (r_frame_rows < FRAME_ROWS_W'(MIN_FRAME_ROWS)) begin
            rows_eff = FRAME_ROWS_W'(MIN_FRAME_ROWS);
        end else if (r_frame_rows > FRAME_ROWS_W'(MAX_FRAME_ROWS)) begin
            rows_eff = FRAME_ROWS_W'(MAX_FRAME_ROWS);
        end
        rows_m1 = ROW_W'(rows_eff - FRAME_ROWS_W'(1));
    end

    assign row_end   = (r_col >= line_len_m1);
    assign on_bottom = (r_row >= rows_m1);

    // room for this byte and the one still in the read stage
    assign i_pix.ready = ({1'b0, i_queue_count} + (QUEUE_CW + 1)'(r_s1_valid))
                         < (QUEUE_CW + 1)'(QUEUE_DEPTH);
    assign accept = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_pixels <= WIDTH_PIX_W'(WIDTH_PIX_RESET);
            r_frame_rows   <= FRAME_ROWS_W'(FRAME_ROWS_RESET);
            r_col          <= '0;
            r_row          <= '0;
            r_s1_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_WIDTH_PIXELS: r_width_pixels <= i_cfg_data[WIDTH_PIX_W-1:0];
                    REG_FRAME_ROWS:   r_frame_rows   <= i_cfg_data[FRAME_ROWS_W-1:0];
                    default: ;
                endcase
            end
            r_s1_valid <= accept;
            if (accept) begin
                if (row_end) begin
                    r_col <= '0;
                    r_row <= on_bottom ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_has_out <= (r_row != '0);
            r_s1_first   <= (r_row == ROW_W'(1));
            r_s1_last    <= on_bottom;
            r_s1_end     <= row_end;
            r_s1_cur     <= i_pix.pixel_byte;
            r_s1_col     <= r_col;
        end
    end

    // both buffers are read at the current column every cycle and written back at that column in the next cycle
    lbd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_ROW_BYTES)
    ) u_line_above (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_cur),
        .i_raddr (r_col),
        .o_rdata (above)
    );

    lbd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_ROW_BYTES)
    ) u_line_two_above (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (above),
        .i_raddr (r_col),
        .o_rdata (two_above)
    );

    assign sum_inner = {1'b0, two_above} + {1'b0, r_s1_cur};
    assign sum_outer = {1'b0, sum_inner[BYTE_W:1]} + {1'b0, above};

    always_comb begin
        o_push             = r_s1_valid && r_s1_has_out;
        o_entry.blend      = r_s1_first ? above : sum_outer[BYTE_W:1];
        o_entry.cur        = r_s1_cur;
        o_entry.bottom_row = r_s1_last;
        o_entry.row_end    = r_s1_end;
    end

endmodule

`default_nettype wire

// File: src/lbd_fifo.sv
// short queue between the front end and the result sequencer
// depends on lbd_pkg
`default_nettype none

module lbd_fifo
    import lbd_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire t_queue_entry  i_entry,
    input  wire logic          i_pop,
    output t_queue_entry       o_head,
    output logic               o_empty,
    output logic [QUEUE_CW-1:0] o_count
);

    t_queue_entry        r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr;
    logic [QUEUE_AW-1:0] r_rptr;
    logic [QUEUE_CW-1:0] r_count;
    logic [QUEUE_CW-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QUEUE_CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QUEUE_AW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    assign o_head  = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != QUEUE_CW'(QUEUE_DEPTH)))
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue read while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// File: src/lbd_back.sv
// result sequencer: expands each queue entry into one or two results
// and holds them in the output register; depends on lbd_pkg, lbd_res_if
`default_nettype none

module lbd_back
    import lbd_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_empty,
    input  wire t_queue_entry i_head,
    output logic              o_pop,
    lbd_res_if.source         o_res
);

    t_result r_out;
    t_result n_out;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    r_second;
    logic    n_second;
    logic    load_ok;
    logic    load;

    assign load_ok = !r_out_valid || o_res.ready;
    assign load    = load_ok && !i_empty;

    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_second    = r_second;
        o_pop       = 1'b0;
        if (load_ok) begin
            n_out_valid = !i_empty;
        end
        if (load) begin
            if (r_second) begin
                // last row: the byte itself follows the row above
                n_out.out_byte  = i_head.cur;
                n_out.frame_end = i_head.row_end;
                n_out.run_last  = 1'b1;
                n_second        = 1'b0;
                o_pop           = 1'b1;
            end else begin
                n_out.out_byte  = i_head.blend;
                n_out.frame_end = 1'b0;
                n_out.run_last  = !i_head.bottom_row;
                n_second        = i_head.bottom_row;
                o_pop           = !i_head.bottom_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_second    <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_second    <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.out_byte  = r_out.out_byte;
    assign o_res.frame_end = r_out.frame_end;
    assign o_res.run_last  = r_out.run_last;

`ifndef SYNTHESIS
    a_second_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (!i_empty && i_head.bottom_row))
        else $error("second result pending without a last-row entry");
    a_second_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_second) |=> (r_out_valid && r_out.run_last))
        else $error("second result not marked as last of its byte");
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_end) |-> r_out.run_last)
        else $error("frame end on a result that is not last of its byte");
`endif

endmodule

`default_nettype wire

// File: src/linear_blend_deinterlacer_unit.sv
// linear blend deinterlacer for a packed 4:2:2 byte stream, top level
// depends on lbd_pkg, lbd_pix_if, lbd_res_if, lbd_front, lbd_fifo, lbd_back
//
// usage:
//   i_pix_ch carries frame bytes in raster order, o_res_ch the filtered bytes,
//   both valid/ready. register 0 sets pixels per row, register 1 rows per
//   frame; write them through i_cfg_we / i_cfg_index / i_cfg_data while idle.
//   output runs one row behind input: row 0 bytes produce nothing, a byte of
//   row 1 produces the byte above it, a byte of a later row produces that byte
//   blended with the rows above and below it, and bytes of the last row also
//   produce themselves, so the last row yields two results per byte.
//   throughput: one byte per cycle while the receiver keeps up; on the last
//   row the single output register, emitting one result a cycle, slows input.
//   a four-entry queue sits between the line buffer stage and the output
//   register, so input keeps flowing while a result waits; when the receiver
//   stalls, i_pix_ch.ready drops once the queue and the read stage together
//   hold four entries.
//   reset clears counters, queue and output register and restores the size
//   registers to 720 x 480; line buffer contents are not cleared.
`default_nettype none

module linear_blend_deinterlacer_unit
    import lbd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    lbd_pix_if.sink                    i_pix_ch,
    lbd_res_if.source                  o_res_ch
);

    logic                push;
    logic                pop;
    logic                empty;
    logic [QUEUE_CW-1:0] queue_count;
    t_queue_entry        entry;
    t_queue_entry        head;

    lbd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pix         (i_pix_ch),
        .i_queue_count (queue_count),
        .o_push        (push),
        .o_entry       (entry)
    );

    lbd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_count (queue_count)
    );

    lbd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_res   (o_res_ch)
    );

endmodule

`default_nettype wire
